// File: rtl/core/czt_pkg.sv
// Shared types, constants and the quarter-wave sine table for the chirp-z bin engine.
`timescale 1ns / 1ps

package czt_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int MAX_BINS    = 8192;
    localparam int SAMPLE_BITS = 16;
    localparam int TABLE_BITS  = 10;

    localparam int TAB_SIZE  = 1 << TABLE_BITS;
    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int ROM_AW    = $clog2(TAB_SIZE + 1);
    localparam int BIN_W     = 13;
    localparam int PHASE_W   = 32;
    localparam int TRIG_W    = 18;
    localparam int PROD_W    = SAMPLE_BITS + TRIG_W;
    localparam int OUT_W     = 40;
    localparam int ACC_W     = OUT_W + 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Function codes of a request
    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_EVAL   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Status codes of a result
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OMEGA,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } czt_state_t;

    typedef logic [16:0] sine_rom_t [0:TAB_SIZE];

    // Taylor series through x^17/17! in Q30, rounded to Q15 and capped at 1.0.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        logic signed [63:0] sum;
        for (int i = 0; i <= TAB_SIZE; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            r = (64'(sum) * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            t[i] = 17'(r);
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/core/chirp_z_transform_bins.sv
// Chirp-z spectrum bins: sample store, phase sequencer and shared complex multiply-accumulate.
`timescale 1ns / 1ps

// Channel     | Signals                                   | Accepted when
// ------------+-------------------------------------------+-------------------------------
// request     | req_valid/req_ready, func, sample,        | req_valid && req_ready
//             | bin_index                                 |
// result      | res_valid/res_ready, bin_real, bin_imag,  | res_valid && res_ready
//             | status                                    |
// config APB  | psel, penable, pwrite, paddr, pwdata,     | psel && penable && pwrite
//             | prdata, pready (always high)              |
//
// Append, clear and unused codes go from accept straight to the finish state, which
// registers the result once the output register is free, and then return to idle.
// An evaluation of a non-empty store passes through the omega, run, drain and finish
// states before the next request is taken: the shared multiply-accumulate unit handles
// one stored sample per cycle, fed by the sample RAM read port and the registered sine
// table, and the pipeline of three stages drains before the sums are saturated.
// Reset (rst_n low, asynchronous) empties the store and zeroes both phases;
// the store needs no clearing pass, the fill count alone marks valid entries.
// req_ready is high only in idle. A stalled result holds in the output
// register; a finished request waits until that register is free.

module chirp_z_transform_bins (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [1:0]                       func,
    input  logic signed [czt_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [czt_pkg::BIN_W-1:0]        bin_index,

    output logic                             res_valid,
    input  logic                             res_ready,
    output logic signed [czt_pkg::OUT_W-1:0] bin_real,
    output logic signed [czt_pkg::OUT_W-1:0] bin_imag,
    output logic [1:0]                       status,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam logic [czt_pkg::PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [czt_pkg::OUT_W-1:0] OUT_MAX = {1'b0, {(czt_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [czt_pkg::OUT_W-1:0] OUT_MIN = {1'b1, {(czt_pkg::OUT_W-1){1'b0}}};

    // Map a phase to its quarter-wave table address; the sign comes from the top bit.
    function automatic logic [czt_pkg::ROM_AW-1:0] rom_addr(input logic [31:0] p);
        logic [czt_pkg::ROM_AW-1:0] j;
        j = czt_pkg::ROM_AW'(p[29 -: czt_pkg::TABLE_BITS]);
        return p[30] ? (czt_pkg::ROM_AW'(czt_pkg::TAB_SIZE) - j) : j;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    czt_pkg::czt_state_t state_reg, state_next;

    logic [31:0]                       start_phase_reg, start_phase_next;
    logic [31:0]                       step_phase_reg, step_phase_next;
    logic [czt_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [czt_pkg::BIN_W-1:0]         bin_reg, bin_next;
    logic [1:0]                        stat_reg, stat_next;
    logic [31:0]                       omega_reg, omega_next;
    logic [31:0]                       phase_reg, phase_next;
    logic [czt_pkg::CNT_W-1:0]         idx_reg, idx_next;

    logic                              v1_reg, v1_next;
    logic                              v2_reg, v2_next;
    logic [16:0]                       cos_mag_reg, cos_mag_next;
    logic [16:0]                       sin_mag_reg, sin_mag_next;
    logic                              cos_neg_reg, cos_neg_next;
    logic                              sin_neg_reg, sin_neg_next;
    logic signed [czt_pkg::PROD_W-1:0] prod_re_reg, prod_re_next;
    logic signed [czt_pkg::PROD_W-1:0] prod_im_reg, prod_im_next;
    logic signed [czt_pkg::ACC_W-1:0]  acc_re_reg, acc_re_next;
    logic signed [czt_pkg::ACC_W-1:0]  acc_im_reg, acc_im_next;

    logic                              res_valid_reg, res_valid_next;
    logic signed [czt_pkg::OUT_W-1:0]  res_real_reg, res_real_next;
    logic signed [czt_pkg::OUT_W-1:0]  res_imag_reg, res_imag_next;
    logic [1:0]                        res_stat_reg, res_stat_next;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic req_fire;
    logic out_free;
    logic issue;
    logic res_load;
    logic last_issue;
    logic store_full;
    logic cfg_write;

    logic                                 ram_we;
    logic [czt_pkg::SAMPLE_BITS-1:0]      ram_rdata;
    logic signed [czt_pkg::TRIG_W-1:0]    cos_val;
    logic signed [czt_pkg::TRIG_W-1:0]    sin_val;
    logic [31:0]                          cos_phase;

    assign req_fire   = req_valid && req_ready;
    assign out_free   = !res_valid_reg || res_ready;
    assign last_issue = (idx_reg + czt_pkg::CNT_W'(1)) == count_reg;
    assign store_full = count_reg >= czt_pkg::CNT_W'(czt_pkg::MAX_SAMPLES);
    assign cfg_write  = psel && penable && pwrite && pready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            czt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (func == czt_pkg::FUNC_EVAL && count_reg != '0)
                    begin
                        state_next = czt_pkg::ST_OMEGA;
                    end
                    else
                    begin
                        state_next = czt_pkg::ST_FINISH;
                    end
                end
            end
            czt_pkg::ST_OMEGA:
            begin
                state_next = czt_pkg::ST_RUN;
            end
            czt_pkg::ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = czt_pkg::ST_DRAIN;
                end
            end
            czt_pkg::ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = czt_pkg::ST_FINISH;
                end
            end
            czt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = czt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = czt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        issue     = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            czt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            czt_pkg::ST_RUN:
            begin
                issue = 1'b1;
            end
            czt_pkg::ST_FINISH:
            begin
                res_load = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sample store
    // ------------------------------------------------------------------
    assign ram_we = req_fire && (func == czt_pkg::FUNC_APPEND) && !store_full;

    czt_ram #(
        .WIDTH (czt_pkg::SAMPLE_BITS),
        .DEPTH (czt_pkg::MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[czt_pkg::ADDR_W-1:0]),
        .wdata (sample),
        .raddr (idx_reg[czt_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign cos_phase = phase_reg + QUARTER_TURN;
    assign cos_val   = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});
    assign sin_val   = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});

    always_comb
    begin
        start_phase_next = start_phase_reg;
        step_phase_next  = step_phase_reg;
        count_next       = count_reg;
        bin_next         = bin_reg;
        stat_next        = stat_reg;
        omega_next       = omega_reg;
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        acc_re_next      = acc_re_reg;
        acc_im_next      = acc_im_reg;
        res_valid_next   = res_valid_reg;
        res_real_next    = res_real_reg;
        res_imag_next    = res_imag_reg;
        res_stat_next    = res_stat_reg;

        // Stage 1: table read alongside the store read
        v1_next      = issue;
        cos_mag_next = czt_pkg::SINE_ROM[rom_addr(cos_phase)];
        sin_mag_next = czt_pkg::SINE_ROM[rom_addr(phase_reg)];
        cos_neg_next = cos_phase[31];
        sin_neg_next = phase_reg[31];

        // Stage 2: the shared complex multiplier
        v2_next      = v1_reg;
        prod_re_next = czt_pkg::PROD_W'($signed(ram_rdata)) * czt_pkg::PROD_W'(cos_val);
        prod_im_next = czt_pkg::PROD_W'($signed(ram_rdata)) * czt_pkg::PROD_W'(sin_val);

        if (cfg_write)
        begin
            if (paddr[2])
            begin
                step_phase_next = pwdata;
            end
            else
            begin
                start_phase_next = pwdata;
            end
        end

        if (req_fire)
        begin
            bin_next    = bin_index;
            stat_next   = czt_pkg::STAT_OK;
            acc_re_next = '0;
            acc_im_next = '0;
            case (func)
                czt_pkg::FUNC_APPEND:
                begin
                    if (store_full)
                    begin
                        stat_next = czt_pkg::STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + czt_pkg::CNT_W'(1);
                    end
                end
                czt_pkg::FUNC_EVAL:
                begin
                    if (count_reg == '0)
                    begin
                        stat_next = czt_pkg::STAT_EMPTY;
                    end
                end
                czt_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    stat_next = czt_pkg::STAT_OK;
                end
            endcase
        end

        if (state_reg == czt_pkg::ST_OMEGA)
        begin
            omega_next = start_phase_reg
                       + 32'(45'(bin_reg) * 45'(step_phase_reg));
            phase_next = '0;
            idx_next   = '0;
        end

        // Advance the phase and the store address one sample per cycle
        if (issue)
        begin
            phase_next = phase_reg + omega_reg;
            idx_next   = idx_reg + czt_pkg::CNT_W'(1);
        end

        // Stage 3: accumulate
        if (v2_reg)
        begin
            acc_re_next = acc_re_reg + czt_pkg::ACC_W'(prod_re_reg);
            acc_im_next = acc_im_reg + czt_pkg::ACC_W'(prod_im_reg);
        end

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        // Load the result register, saturating both sums to 40 bits
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_stat_next  = stat_reg;
            if (acc_re_reg[czt_pkg::ACC_W-1] != acc_re_reg[czt_pkg::ACC_W-2])
            begin
                res_real_next = acc_re_reg[czt_pkg::ACC_W-1] ? OUT_MIN : OUT_MAX;
            end
            else
            begin
                res_real_next = acc_re_reg[czt_pkg::OUT_W-1:0];
            end
            if (acc_im_reg[czt_pkg::ACC_W-1] != acc_im_reg[czt_pkg::ACC_W-2])
            begin
                res_imag_next = acc_im_reg[czt_pkg::ACC_W-1] ? OUT_MIN : OUT_MAX;
            end
            else
            begin
                res_imag_next = acc_im_reg[czt_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= czt_pkg::ST_IDLE;
            start_phase_reg <= '0;
            step_phase_reg  <= '0;
            count_reg       <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            start_phase_reg <= start_phase_next;
            step_phase_reg  <= step_phase_next;
            count_reg       <= count_next;
            v1_reg          <= v1_next;
            v2_reg          <= v2_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        stat_reg     <= stat_next;
        omega_reg    <= omega_next;
        phase_reg    <= phase_next;
        idx_reg      <= idx_next;
        cos_mag_reg  <= cos_mag_next;
        sin_mag_reg  <= sin_mag_next;
        cos_neg_reg  <= cos_neg_next;
        sin_neg_reg  <= sin_neg_next;
        prod_re_reg  <= prod_re_next;
        prod_im_reg  <= prod_im_next;
        acc_re_reg   <= acc_re_next;
        acc_im_reg   <= acc_im_next;
        res_real_reg <= res_real_next;
        res_imag_reg <= res_imag_next;
        res_stat_reg <= res_stat_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign res_valid = res_valid_reg;
    assign bin_real  = res_real_reg;
    assign bin_imag  = res_imag_reg;
    assign status    = res_stat_reg;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? step_phase_reg : start_phase_reg;

endmodule

// File: rtl/core/czt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module czt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sim/chirp_z_transform_bins_test.sv
// Self-checking testbench for the chirp-z bin engine: directed cases, random sequences, stalls.
`timescale 1ns / 1ps

module chirp_z_transform_bins_test;

    import czt_pkg::*;

    // The request code that the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Register byte addresses on the APB port
    localparam logic [2:0] REG_START_PHASE = 3'd0;
    localparam logic [2:0] REG_STEP_PHASE  = 3'd4;

    localparam longint BIN_MAX = 64'sd549755813887;
    localparam longint BIN_MIN = -64'sd549755813888;

    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic [1:0]              st;
    } bin_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                          req_valid = 1'b0;
    logic                          req_ready;
    logic [1:0]                    func      = FUNC_APPEND;
    logic signed [SAMPLE_BITS-1:0] sample    = '0;
    logic [BIN_W-1:0]              bin_index = '0;

    logic                          res_valid;
    logic                          res_ready = 1'b0;
    logic signed [OUT_W-1:0]       bin_real;
    logic signed [OUT_W-1:0]       bin_imag;
    logic [1:0]                    status;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Own copy of the block state: sample store, fill count and both phases
    logic [16:0]                   quarter_sine [0:TAB_SIZE];
    logic signed [SAMPLE_BITS-1:0] stored_samples [0:MAX_SAMPLES-1];
    int                            stored_count;
    logic [31:0]                   start_phase_reg;
    logic [31:0]                   step_phase_reg;

    // Results still owed by the block, oldest first
    bin_result_t expected_bins[$];

    int fail_count      = 0;
    int requests_sent   = 0;
    int hold_off_cycles = 0;
    bit producer_idle   = 1'b1;
    bit consumer_idle   = 1'b1;

    chirp_z_transform_bins dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .func      (func),
        .sample    (sample),
        .bin_index (bin_index),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .bin_real  (bin_real),
        .bin_imag  (bin_imag),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run; a correct run ends far earlier.
    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Quarter-wave sine in Q1.15: Taylor series through x^17/17! in Q30,
    // truncating every product and every factorial division, then round half
    // up to Q15 and cap at 1.0.
    function automatic void fill_quarter_sine();
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        logic [63:0] rounded;
        longint      acc;
        for (int i = 0; i <= TAB_SIZE; i++)
        begin
            ang    = (64'd1686629713 * 64'(i)) >> TABLE_BITS;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            rounded = (64'(acc) * 64'd32768 + 64'd536870912) >> 30;
            if (rounded > 64'd32768)
                rounded = 64'd32768;
            quarter_sine[i] = 17'(rounded);
        end
    endfunction

    // Sine of a 32-bit turn fraction: truncate to the table index, mirror in
    // odd quadrants, negate in the lower half.
    function automatic logic signed [17:0] sine_of_phase(input logic [31:0] p);
        int                 j;
        logic signed [17:0] v;
        j = int'(p[29:30-TABLE_BITS]);
        if (p[30])
            v = $signed({1'b0, quarter_sine[TAB_SIZE - j]});
        else
            v = $signed({1'b0, quarter_sine[j]});
        return p[31] ? -v : v;
    endfunction

    function automatic logic signed [OUT_W-1:0] clip_to_bin(input longint v);
        if (v > BIN_MAX)
            v = BIN_MAX;
        if (v < BIN_MIN)
            v = BIN_MIN;
        return OUT_W'(v);
    endfunction

    // Apply one request to the state copy and return the result it owes.
    function automatic bin_result_t predict_bin(input logic [1:0] f,
                                                input logic signed [SAMPLE_BITS-1:0] s,
                                                input logic [BIN_W-1:0] k);
        bin_result_t r;
        logic [31:0] omega;
        logic [31:0] ph;
        longint      acc_re;
        longint      acc_im;
        int          kk;
        r.re   = '0;
        r.im   = '0;
        r.st   = STAT_OK;
        acc_re = 0;
        acc_im = 0;
        case (f)
            FUNC_APPEND:
            begin
                if (stored_count < MAX_SAMPLES)
                begin
                    stored_samples[stored_count] = s;
                    stored_count++;
                end
                else
                    r.st = STAT_FULL;
            end
            FUNC_EVAL:
            begin
                kk = int'(k);
                if (kk > MAX_BINS - 1)
                    kk = MAX_BINS - 1;
                if (stored_count == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    omega = start_phase_reg + 32'(kk) * step_phase_reg;
                    ph    = '0;
                    for (int n = 0; n < stored_count; n++)
                    begin
                        acc_re += longint'(stored_samples[n])
                                  * longint'(sine_of_phase(ph + 32'h4000_0000));
                        acc_im += longint'(stored_samples[n]) * longint'(sine_of_phase(ph));
                        ph += omega;
                    end
                    r.re = clip_to_bin(acc_re);
                    r.im = clip_to_bin(acc_im);
                end
            end
            FUNC_CLEAR:
                stored_count = 0;
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: idle in random bursts, and hold off for a long stretch
    // when a test asks for it, counting the cycles here.
    // ------------------------------------------------------------------
    initial
    begin : result_consumer
        int busy;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                res_ready <= 1'b0;
                busy = hold_off_cycles;
                repeat (busy) @(posedge clk);
                hold_off_cycles = 0;
                res_ready <= 1'b1;
            end
            else if (consumer_idle && $urandom_range(0, 7) == 0)
            begin
                res_ready <= 1'b0;
                busy = $urandom_range(1, 14);
                repeat (busy) @(posedge clk);
                res_ready <= 1'b1;
                // leave a ready stretch after the burst
                busy = $urandom_range(0, 40);
                repeat (busy) @(posedge clk);
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest one still owed.
    always @(posedge clk)
    begin : result_check
        bin_result_t want;
        if (res_valid === 1'b1 && res_ready === 1'b1)
        begin
            if (expected_bins.size() == 0)
            begin
                $error("unexpected result: bin_real %0d, bin_imag %0d, status %0d",
                       bin_real, bin_imag, status);
                fail_count++;
            end
            else
            begin
                want = expected_bins.pop_front();
                if (bin_real !== want.re)
                begin
                    $error("bin_real mismatch: expected %0d, actual %0d", want.re, bin_real);
                    fail_count++;
                end
                if (bin_imag !== want.im)
                begin
                    $error("bin_imag mismatch: expected %0d, actual %0d", want.im, bin_imag);
                    fail_count++;
                end
                if (status !== want.st)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.st, status);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side. Every call starts in the time step of a rising edge.
    // Keep valid high straight into the next request when there is no gap,
    // so valid gets a single assignment per step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] f,
                                input logic [SAMPLE_BITS-1:0] s,
                                input logic [BIN_W-1:0] k);
        int gap;
        gap = 0;
        if (producer_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        sample    <= s;
        bin_index <= k;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        expected_bins.push_back(predict_bin(f, $signed(s), k));
        requests_sent++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == REG_START_PHASE)
            start_phase_reg = data;
        else if (addr == REG_STEP_PHASE)
            step_phase_reg = data;
    endtask

    // Reprogram both phases with the block idle.
    task automatic set_phases(input logic [31:0] start_val, input logic [31:0] step_val);
        wait_idle();
        apb_write(REG_START_PHASE, start_val);
        apb_write(REG_STEP_PHASE, step_val);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [BIN_W-1:0] pick_bin();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return 13'($urandom);
        endcase
    endfunction

    // Occasionally slip in a request of any code with random fields.
    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 6)
            send_request(2'($urandom), 16'($urandom), 13'($urandom));
    endtask

    // One sequence: a clear in most cases, then a fill and a few bin evaluations.
    // Most fills are short; a few run past the store size.
    task automatic run_sequence();
        int pick;
        int n_samples;
        int n_evals;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            n_samples = $urandom_range(1, 24);
        else if (pick < 95)
            n_samples = $urandom_range(25, 255);
        else
            n_samples = $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 4);
        if ($urandom_range(0, 9) != 0)
            send_request(FUNC_CLEAR, 16'($urandom), 13'($urandom));
        repeat (n_samples)
        begin
            maybe_noise();
            send_request(FUNC_APPEND, pick_sample(), 13'($urandom));
        end
        n_evals = $urandom_range(1, 6);
        repeat (n_evals)
        begin
            maybe_noise();
            send_request(FUNC_EVAL, 16'($urandom), pick_bin());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Evaluate and clear an empty store, issue the unused code, then sum a
    // few samples with both phases at zero.
    task automatic test_empty_store();
        send_request(FUNC_EVAL, 16'h1234, '0);
        send_request(FUNC_CLEAR, 16'hFFFF, '1);
        send_request(FUNC_UNUSED, 16'h7FFF, '1);
        send_request(FUNC_EVAL, '0, 13'd5);
        send_request(FUNC_APPEND, 16'h2000, '0);
        send_request(FUNC_APPEND, 16'hE000, '0);
        send_request(FUNC_APPEND, 16'h0001, '0);
        send_request(FUNC_EVAL, '0, '0);
        send_request(FUNC_UNUSED, '0, '0);
        send_request(FUNC_EVAL, '0, '1);
    endtask

    // Extreme samples, bin indexes and phase registers.
    task automatic test_field_extremes();
        set_phases(32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_CLEAR, '0, '0);
        send_request(FUNC_APPEND, 16'h8000, '0);
        send_request(FUNC_APPEND, 16'h7FFF, '1);
        send_request(FUNC_APPEND, 16'hFFFF, '0);
        send_request(FUNC_APPEND, 16'h0000, '1);
        send_request(FUNC_APPEND, 16'h5555, '0);
        send_request(FUNC_EVAL, 16'hFFFF, '0);
        set_phases(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_EVAL, '0, '0);
        send_request(FUNC_EVAL, '0, '1);
        send_request(FUNC_EVAL, '0, 13'h0AAA);
        set_phases(32'h4000_0000, 32'h0010_0000);
        send_request(FUNC_EVAL, '0, '0);
        send_request(FUNC_EVAL, '0, 13'h1555);
        send_request(FUNC_EVAL, '0, '1);
    endtask

    // Fill the store with the most negative sample, append past the end,
    // and evaluate at zero phase for the largest sums.
    task automatic test_store_full();
        set_phases(32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_CLEAR, '0, '0);
        repeat (MAX_SAMPLES)
            send_request(FUNC_APPEND, 16'h8000, 13'($urandom));
        send_request(FUNC_APPEND, 16'h7FFF, '0);
        send_request(FUNC_APPEND, 16'h8000, '0);
        send_request(FUNC_EVAL, '0, '0);
        set_phases(32'h8000_0000, 32'h0000_0001);
        send_request(FUNC_EVAL, '0, '0);
        send_request(FUNC_EVAL, '0, '1);
        send_request(FUNC_CLEAR, '0, '0);
        send_request(FUNC_EVAL, '0, 13'd7);
    endtask

    // Hold the result side off long enough that the block stops accepting,
    // while requests keep coming back to back.
    task automatic test_input_stall();
        set_phases($urandom, $urandom);
        producer_idle = 1'b0;
        hold_off_cycles = 400;
        send_request(FUNC_CLEAR, '0, '0);
        repeat (8)
            send_request(FUNC_APPEND, pick_sample(), '0);
        repeat (8)
            send_request(FUNC_EVAL, '0, pick_bin());
        producer_idle = 1'b1;
    endtask

    // Random sequences under several phase settings, extremes first.
    task automatic test_random_phases();
        int base;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_phases(32'h0000_0000, 32'h0000_0000);
                1: set_phases(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_phases(32'h0000_0000, 32'hFFFF_FFFF);
                3: set_phases(32'hFFFF_FFFF, 32'h0000_0000);
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        set_phases($urandom, $urandom_range(0, 1 << 24));
                    else
                        set_phases($urandom, $urandom);
                end
            endcase
            base = requests_sent;
            while (requests_sent - base < 130)
                run_sequence();
        end
    endtask

    // Last stretch with no idling on either side.
    task automatic test_steady_stream();
        int base;
        set_phases($urandom, $urandom);
        producer_idle = 1'b0;
        consumer_idle = 1'b0;
        base = requests_sent;
        while (requests_sent - base < 150)
            run_sequence();
    endtask

    initial
    begin
        fill_quarter_sine();
        stored_count    = 0;
        start_phase_reg = '0;
        step_phase_reg  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_field_extremes();
        test_store_full();
        test_input_stall();
        test_random_phases();
        test_steady_stream();

        // Drain, then allow one more evaluation's worth of cycles for strays.
        wait_idle();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: chirp_z_transform_bins.f
rtl/core/czt_pkg.sv
rtl/core/czt_ram.sv
rtl/core/chirp_z_transform_bins.sv
sim/chirp_z_transform_bins_test.sv
